// ----- hw/rtl/ps2mct_pkg.sv -----
// types and constants shared by the mouse packet cursor tracker
// no dependencies
package ps2mct_pkg;

    localparam int unsigned POS_W  = 12;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BTN_W  = 3;
    localparam int unsigned SUM_W  = POS_W + 2;

    // header bit positions
    localparam int unsigned HDR_SYNC_BIT  = 3;
    localparam int unsigned HDR_XSIGN_BIT = 4;
    localparam int unsigned HDR_YSIGN_BIT = 5;

    // reset values
    localparam logic [POS_W-1:0] RESET_LIMIT_X = 12'd1010;
    localparam logic [POS_W-1:0] RESET_LIMIT_Y = 12'd750;
    localparam logic [POS_W-1:0] RESET_POS_X   = 12'd512;
    localparam logic [POS_W-1:0] RESET_POS_Y   = 12'd384;

    // register index codes
    localparam logic REG_LIMIT_X = 1'b0;
    localparam logic REG_LIMIT_Y = 1'b1;

    // place of the next byte within a packet
    typedef enum logic [1:0] {
        BP_HEADER = 2'd0,
        BP_XBYTE  = 2'd1,
        BP_YBYTE  = 2'd2
    } t_byte_pos;

    typedef struct packed {
        logic [POS_W-1:0] limit_x;
        logic [POS_W-1:0] limit_y;
    } t_limits;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic [BTN_W-1:0] button_bits;
    } t_result;

endpackage

// ----- hw/rtl/ps2mct_regs.sv -----
// configuration registers for the cursor limits, apb-style access
// depends on ps2mct_pkg
module ps2mct_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output ps2mct_pkg::t_limits   o_limits
);

    logic [ps2mct_pkg::POS_W-1:0] r_limit_x, n_limit_x;
    logic [ps2mct_pkg::POS_W-1:0] r_limit_y, n_limit_y;
    logic                         wr_en;
    logic                         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // write decode
    always_comb begin
        n_limit_x = r_limit_x;
        n_limit_y = r_limit_y;
        if (wr_en) begin
            unique case (reg_idx)
                ps2mct_pkg::REG_LIMIT_X: n_limit_x = pwdata[ps2mct_pkg::POS_W-1:0];
                ps2mct_pkg::REG_LIMIT_Y: n_limit_y = pwdata[ps2mct_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x <= ps2mct_pkg::RESET_LIMIT_X;
            r_limit_y <= ps2mct_pkg::RESET_LIMIT_Y;
        end else begin
            r_limit_x <= n_limit_x;
            r_limit_y <= n_limit_y;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            ps2mct_pkg::REG_LIMIT_X: prdata = {20'd0, r_limit_x};
            ps2mct_pkg::REG_LIMIT_Y: prdata = {20'd0, r_limit_y};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_limits.limit_x = r_limit_x;
    assign o_limits.limit_y = r_limit_y;

endmodule

// ----- hw/rtl/ps2mct_core.sv -----
// packet assembly and cursor update, state advances on i_advance
// depends on ps2mct_pkg
module ps2mct_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic [ps2mct_pkg::BYTE_W-1:0]     i_byte,
    input  ps2mct_pkg::t_limits               i_limits,
    output logic                              o_has_result,
    output ps2mct_pkg::t_result               o_result
);

    localparam int unsigned SW = ps2mct_pkg::SUM_W;
    localparam int unsigned PW = ps2mct_pkg::POS_W;

    ps2mct_pkg::t_byte_pos        r_pos, n_pos;
    logic [ps2mct_pkg::BYTE_W-1:0] r_header, n_header;
    logic [ps2mct_pkg::BYTE_W-1:0] r_xbyte, n_xbyte;
    logic [PW-1:0]                r_pos_x, n_pos_x;
    logic [PW-1:0]                r_pos_y, n_pos_y;
    logic [ps2mct_pkg::BTN_W-1:0] r_buttons, n_buttons;

    logic          x_sign, y_sign;
    logic [SW-1:0] sum_x, sum_y;
    logic [PW-1:0] clamp_x, clamp_y;

    // next byte position
    always_comb begin
        n_pos = r_pos;
        if (i_advance) begin
            unique case (r_pos)
                ps2mct_pkg::BP_XBYTE: n_pos = ps2mct_pkg::BP_YBYTE;
                ps2mct_pkg::BP_YBYTE: n_pos = ps2mct_pkg::BP_HEADER;
                default: begin
                    if (i_byte[ps2mct_pkg::HDR_SYNC_BIT]) begin
                        n_pos = ps2mct_pkg::BP_XBYTE;
                    end else begin
                        n_pos = ps2mct_pkg::BP_HEADER;
                    end
                end
            endcase
        end
    end

    // outputs of the sequencer
    always_comb begin
        unique case (r_pos)
            ps2mct_pkg::BP_YBYTE: o_has_result = 1'b1;
            default:              o_has_result = 1'b0;
        endcase
    end

    // signed deltas and saturating update
    assign x_sign = r_header[ps2mct_pkg::HDR_XSIGN_BIT];
    assign y_sign = r_header[ps2mct_pkg::HDR_YSIGN_BIT];
    assign sum_x  = {2'b00, r_pos_x} + {{(SW-ps2mct_pkg::BYTE_W){x_sign}}, r_xbyte};
    assign sum_y  = {2'b00, r_pos_y} - {{(SW-ps2mct_pkg::BYTE_W){y_sign}}, i_byte};

    always_comb begin
        if (sum_x[SW-1]) begin
            clamp_x = '0;
        end else if (sum_x[SW-2:0] > {1'b0, i_limits.limit_x}) begin
            clamp_x = i_limits.limit_x;
        end else begin
            clamp_x = sum_x[PW-1:0];
        end
        if (sum_y[SW-1]) begin
            clamp_y = '0;
        end else if (sum_y[SW-2:0] > {1'b0, i_limits.limit_y}) begin
            clamp_y = i_limits.limit_y;
        end else begin
            clamp_y = sum_y[PW-1:0];
        end
    end

    // data state updates
    always_comb begin
        n_header  = r_header;
        n_xbyte   = r_xbyte;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        if (i_advance) begin
            unique case (r_pos)
                ps2mct_pkg::BP_XBYTE: n_xbyte = i_byte;
                ps2mct_pkg::BP_YBYTE: begin
                    n_pos_x   = clamp_x;
                    n_pos_y   = clamp_y;
                    n_buttons = r_header[ps2mct_pkg::BTN_W-1:0];
                end
                default: begin
                    if (i_byte[ps2mct_pkg::HDR_SYNC_BIT]) begin
                        n_header = i_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= ps2mct_pkg::BP_HEADER;
            r_header  <= '0;
            r_xbyte   <= '0;
            r_pos_x   <= ps2mct_pkg::RESET_POS_X;
            r_pos_y   <= ps2mct_pkg::RESET_POS_Y;
            r_buttons <= '0;
        end else begin
            r_pos     <= n_pos;
            r_header  <= n_header;
            r_xbyte   <= n_xbyte;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= n_buttons;
        end
    end

    assign o_result.cursor_x    = clamp_x;
    assign o_result.cursor_y    = clamp_y;
    assign o_result.button_bits = r_header[ps2mct_pkg::BTN_W-1:0];

endmodule

// ----- hw/rtl/ps2_mouse_packet_cursor_tracker_top.sv -----
// a packet's third byte is held in the input register, and its result then in the result register
// throughput: one byte per cycle while not stalled, set by the single input register stage
// the input stalls only when a third byte meets a result still waiting
// reset: synchronous active low, clears handshakes, packet position, cursor
// to 512/384 and limits to 1010/750
module ps2_mouse_packet_cursor_tracker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_cursor_x,
    output logic [11:0] o_cursor_y,
    output logic [2:0]  o_button_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ps2mct_pkg::t_limits limits;
    ps2mct_pkg::t_result core_result;
    ps2mct_pkg::t_result r_out, n_out;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte, n_in_byte;
    logic       r_out_valid, n_out_valid;
    logic       has_result, out_free, advance, in_take;

    ps2mct_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    ps2mct_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_byte       (r_in_byte),
        .i_limits     (limits),
        .o_has_result (has_result),
        .o_result     (core_result)
    );

    // handshake control
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!has_result || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    // input register
    always_comb begin
        n_in_byte = r_in_byte;
        if (in_take) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_data_byte;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    // result register
    always_comb begin
        n_out = r_out;
        if (advance && has_result) begin
            n_out_valid = 1'b1;
            n_out       = core_result;
        end else if (out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
        r_out     <= n_out;
    end

    assign o_valid       = r_out_valid;
    assign o_cursor_x    = r_out.cursor_x;
    assign o_cursor_y    = r_out.cursor_y;
    assign o_button_bits = r_out.button_bits;

endmodule

// ----- hw/rtl/ps2mct_checker.sv -----
// port-level checks for the cursor tracker top level, with its bind
// depends on ps2_mouse_packet_cursor_tracker_top
module ps2mct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [11:0] o_cursor_x,
    input logic [11:0] o_cursor_y,
    input logic [2:0]  o_button_bits
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cursor_x) && $stable(o_cursor_y)
            && $stable(o_button_bits))
        else $error("stalled result changed");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    // reset empties both stages
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("handshake not cleared by reset");

endmodule

bind ps2_mouse_packet_cursor_tracker_top ps2mct_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_cursor_x    (o_cursor_x),
    .o_cursor_y    (o_cursor_y),
    .o_button_bits (o_button_bits)
);
